// File: src/bas_pkg.sv
// Shared types and constants for the advertising scan selector.
// No dependencies; every other file of the block imports this package.
package bas_pkg;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int RSSI_W  = 8;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 2;

    // Longest report the walker will look at
    localparam int MAX_REPORT_BYTES = 62;

    // Request actions
    localparam logic [1:0] ACT_SCAN_START  = 2'd0;
    localparam logic [1:0] ACT_REPORT_BYTE = 2'd1;
    localparam logic [1:0] ACT_SCAN_STOP   = 2'd2;

    // Scan stop decisions
    localparam logic [1:0] DEC_CONNECT       = 2'd0;
    localparam logic [1:0] DEC_NO_DEVICE     = 2'd1;
    localparam logic [1:0] DEC_TARGET_ABSENT = 2'd2;
    localparam logic [1:0] DEC_ZERO_ADDRESS  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RECONNECT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RSSI       = 2'd2;

    // Reset values and constants
    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR_RESET = -8'sd80;
    localparam logic signed [RSSI_W-1:0] RSSI_NONE        = -8'sd128;
    localparam logic [BYTE_W-1:0] AD_MANUF    = 8'hFF;
    localparam logic [BYTE_W-1:0] MFR_BYTE0   = 8'hAA;
    localparam logic [BYTE_W-1:0] MFR_BYTE1   = 8'h08;
    localparam logic [BYTE_W-1:0] MFR_BYTE4   = 8'hFA;
    localparam logic [BYTE_W-1:0] MFR_MIN_LEN = 8'd6;
    localparam logic [LEN_W-1:0]  POS_LIMIT   = 6'd63;

    // Input request
    typedef struct packed {
        logic [1:0]               action;
        logic [BYTE_W-1:0]        adv_byte;
        logic [LEN_W-1:0]         report_length;
        logic                     last_byte;
        logic signed [RSSI_W-1:0] rssi;
        logic [ADDR_W-1:0]        device_address;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic [1:0]               decision;
        logic [ADDR_W-1:0]        chosen_address;
        logic signed [RSSI_W-1:0] chosen_rssi;
    } out_item_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic                     reconnect_mode;
        logic [ADDR_W-1:0]        target_address;
        logic signed [RSSI_W-1:0] min_rssi;
    } cfg_t;

endpackage

// File: src/bas_parser.sv
// AD structure walker: tracks the per-report parse state and flags a match.
// Depends on bas_pkg.
module bas_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  bas_pkg::in_item_t item,
    output logic             matched_now
);
    import bas_pkg::*;

    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  start_reg, start_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic              stopped_reg, stopped_next;
    logic [1:0]        prefix_reg, prefix_next;
    logic              matched_reg, matched_next;

    logic [LEN_W-1:0]  adv_len;
    logic [LEN_W-1:0]  off;
    logic [8:0]        elem_end;
    logic              take;
    logic              clear;

    // Effective report length and offset within the current structure
    assign adv_len  = (32'(item.report_length) > MAX_REPORT_BYTES) ?
                      LEN_W'(MAX_REPORT_BYTES) : item.report_length;
    assign off      = pos_reg - start_reg;
    assign elem_end = 9'(start_reg) + 9'(item.adv_byte) + 9'd1;

    assign take  = fire && (item.action == ACT_REPORT_BYTE);
    assign clear = fire && ((item.action == ACT_SCAN_START) ||
                            (item.action == ACT_SCAN_STOP) ||
                            (item.action == ACT_REPORT_BYTE && item.last_byte));

    // Walk one byte
    always_comb begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        stopped_next = stopped_reg;
        prefix_next  = prefix_reg;
        matched_next = matched_reg;
        if (take) begin
            if (!stopped_reg && !matched_reg && (pos_reg < adv_len)) begin
                if (off == '0) begin
                    if (item.adv_byte == '0 || elem_end > 9'(adv_len)) begin
                        stopped_next = 1'b1;
                    end else begin
                        len_next    = item.adv_byte;
                        prefix_next = 2'd0;
                    end
                end else if (off == 6'd1) begin
                    type_next = item.adv_byte;
                end else if (type_reg == AD_MANUF && len_reg >= MFR_MIN_LEN) begin
                    if (off == 6'd2) begin
                        prefix_next = (item.adv_byte == MFR_BYTE0) ? 2'd1 : 2'd0;
                    end else if (off == 6'd3) begin
                        prefix_next = (prefix_reg == 2'd1 && item.adv_byte == MFR_BYTE1) ?
                                      2'd2 : 2'd0;
                    end else if (off == 6'd6) begin
                        if (prefix_reg == 2'd2 && item.adv_byte == MFR_BYTE4) begin
                            matched_next = 1'b1;
                        end
                    end
                end
                // next structure starts after the last byte of this one
                if (off != '0 && {2'b00, off} == len_reg) begin
                    start_next = pos_reg + 6'd1;
                end
            end
            if (pos_reg < POS_LIMIT) begin
                pos_next = pos_reg + 6'd1;
            end
        end
    end

    assign matched_now = matched_next;

    // Parse state, cleared between reports
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pos_reg     <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            stopped_reg <= 1'b0;
            prefix_reg  <= '0;
            matched_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            stopped_reg <= stopped_next;
            prefix_reg  <= prefix_next;
            matched_reg <= matched_next;
        end
    end

endmodule

// File: src/bas_select.sv
// Device selection across a scan and the scan stop decision.
// Depends on bas_pkg.
module bas_select (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  bas_pkg::in_item_t item,
    input  bas_pkg::cfg_t     cfg,
    input  logic              matched_now,
    output bas_pkg::out_item_t result
);
    import bas_pkg::*;

    logic signed [RSSI_W-1:0] best_rssi_reg, best_rssi_next;
    logic [ADDR_W-1:0]        lead_addr_reg, lead_addr_next;
    logic                     found_reg, found_next;
    logic [ADDR_W-1:0]        conn_addr;

    // Clear the selection on scan start; update it on the last byte of a matching report
    always_comb begin
        best_rssi_next = best_rssi_reg;
        lead_addr_next = lead_addr_reg;
        found_next     = found_reg;
        if (fire) begin
            if (item.action == ACT_SCAN_START) begin
                best_rssi_next = RSSI_NONE;
                lead_addr_next = '0;
                found_next     = 1'b0;
            end else if (item.action == ACT_REPORT_BYTE && item.last_byte && matched_now) begin
                if (cfg.reconnect_mode) begin
                    if (item.device_address == cfg.target_address) begin
                        found_next     = 1'b1;
                        best_rssi_next = item.rssi;
                    end
                end else if (item.rssi > best_rssi_reg && item.rssi >= cfg.min_rssi) begin
                    best_rssi_next = item.rssi;
                    lead_addr_next = item.device_address;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_rssi_reg <= RSSI_NONE;
            lead_addr_reg <= '0;
            found_reg     <= 1'b0;
        end else begin
            best_rssi_reg <= best_rssi_next;
            lead_addr_reg <= lead_addr_next;
            found_reg     <= found_next;
        end
    end

    // Connect decision from the current selection
    assign conn_addr = cfg.reconnect_mode ? cfg.target_address : lead_addr_reg;

    always_comb begin
        result.chosen_address = '0;
        result.chosen_rssi    = best_rssi_reg;
        priority if (best_rssi_reg == RSSI_NONE) begin
            result.decision = DEC_NO_DEVICE;
        end else if (cfg.reconnect_mode && !found_reg) begin
            result.decision = DEC_TARGET_ABSENT;
        end else if (conn_addr == '0) begin
            result.decision = DEC_ZERO_ADDRESS;
        end else begin
            result.decision       = DEC_CONNECT;
            result.chosen_address = conn_addr;
        end
    end

endmodule

// File: src/ble_adv_scan_selector.sv
// Advertising scan selector: one report byte or scan command per request.
// s_ channel carries requests (scan start, report byte, scan stop); a scan
// start clears the selection, report bytes are walked as AD structures and
// the last byte of a matching report updates the selected device.
// m_ channel carries one result per scan stop: decision, address and RSSI.
// cfg_we/cfg_index/cfg_wdata write reconnect_mode (0), target_address (1)
// and min_rssi (2); write only while the block is idle.
// Throughput: one request per cycle while no scan stop waits for the result
// register. Each request is registered on entry and handled by the parser
// and selector from there; a scan stop result then goes to m_valid.
// The rate is set by the update of the parse and selection state, which
// each request reads and writes once.
// If the receiver stalls with a result held, requests other than scan stop
// keep flowing; a scan stop waits in the input register until the result
// register is free, and s_ready drops behind it.
// Reset (aresetn low, synchronous) clears the parse state, the selection,
// both valids and the registers to their defaults (min_rssi -80 dBm).
// Depends on bas_pkg, bas_parser and bas_select.
module ble_adv_scan_selector (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bas_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bas_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [bas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bas_pkg::CFG_W-1:0]     cfg_wdata
);
    import bas_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  stg_item_reg;
    logic      stg_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      matched_now;
    logic      is_stop;
    logic      advance;
    logic      fire;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reconnect_mode <= 1'b0;
            cfg_reg.target_address <= '0;
            cfg_reg.min_rssi       <= RSSI_FLOOR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RECONNECT_MODE: cfg_reg.reconnect_mode <= cfg_wdata[0];
                REG_TARGET_ADDRESS: cfg_reg.target_address <= cfg_wdata[ADDR_W-1:0];
                REG_MIN_RSSI:       cfg_reg.min_rssi       <= signed'(cfg_wdata[RSSI_W-1:0]);
                default: ;
            endcase
        end
    end

    // Stage handshake: a scan stop moves on only into a free result slot
    assign is_stop = (stg_item_reg.action == ACT_SCAN_STOP);
    assign advance = !(is_stop && out_valid_reg && !m_ready);
    assign fire    = stg_valid_reg && advance;
    assign s_ready = !stg_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stg_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stg_item_reg <= s_data;
        end
    end

    bas_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (stg_item_reg),
        .matched_now (matched_now)
    );

    bas_select u_select (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (stg_item_reg),
        .cfg         (cfg_reg),
        .matched_now (matched_now),
        .result      (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && is_stop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && is_stop) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule
